[hdl/tcpq_pkg.sv]
// Shared types and constants for the three-class priority queue.
package tcpq_pkg;

    localparam int CAPACITY  = 64;
    localparam int NCLASS    = 3;
    localparam int CLASS_MIN = 1;
    localparam int CLASS_MAX = 3;
    localparam int SLOT_W    = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int CLS_IDX_W = $clog2(NCLASS);

    typedef logic [SLOT_W-1:0]    slot_t;
    typedef logic [CNT_W-1:0]     cnt_t;
    typedef logic [CLS_IDX_W-1:0] cls_idx_t;

    typedef enum logic {
        MODE_REGISTER = 1'b0,
        MODE_DISPATCH = 1'b1
    } mode_t;

    typedef enum logic [2:0] {
        ST_QUEUED     = 3'd0,
        ST_DISPATCHED = 3'd1,
        ST_EMPTY      = 3'd2,
        ST_FULL       = 3'd3,
        ST_BADCLASS   = 3'd4
    } status_t;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    typedef struct packed {
        logic [15:0] id;
        logic [1:0]  cls;
        logic [15:0] weight;
    } entry_t;

    typedef struct packed {
        mode_t       mode;
        logic [15:0] item_id;
        logic [1:0]  item_class;
        logic [15:0] item_weight;
    } in_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] out_id;
        logic [1:0]  out_class;
        logic [15:0] out_weight;
        logic [6:0]  fill_level;
    } out_t;

    typedef struct packed {
        logic   rd_en;
        slot_t  rd_addr;
        logic   ent_we;
        slot_t  ent_addr;
        entry_t ent_data;
        logic   lnk_we;
        slot_t  lnk_addr;
        slot_t  lnk_data;
    } mem_req_t;

    typedef struct packed {
        entry_t ent;
        slot_t  lnk;
    } mem_rsp_t;

endpackage

[hdl/three_class_priority_queue.sv]
// Three-class priority queue, first-in first-out within each class, top level.
// The transfer cycle issues the single read of the slot memories (free-chain link for a
// register item, head entry and link for a dispatch); the execute state, held while a
// result waits untaken, updates the class lists, writes back and loads the result
// register. No new item is taken until the execute state is done.
// A new item is accepted while the previous result still waits in the output register.
// The link memory needs no clearing pass after reset: a high-water mark of slots ever
// allocated stands in for the initial free chain, so items are taken right after reset.
module three_class_priority_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  tcpq_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output tcpq_pkg::out_t m_data
);

    tcpq_pkg::mem_req_t mem_req;
    tcpq_pkg::mem_rsp_t mem_rsp;

    tcpq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .mem_req (mem_req),
        .mem_rsp (mem_rsp)
    );

    tcpq_store u_store (
        .aclk (aclk),
        .req  (mem_req),
        .rsp  (mem_rsp)
    );

endmodule

[hdl/tcpq_store.sv]
// Slot pool memories: entry store and link store, one shared registered read port.
module tcpq_store (
    input  logic               aclk,
    input  tcpq_pkg::mem_req_t req,
    output tcpq_pkg::mem_rsp_t rsp
);

    tcpq_pkg::entry_t ent_mem [tcpq_pkg::CAPACITY];
    tcpq_pkg::slot_t  lnk_mem [tcpq_pkg::CAPACITY];
    tcpq_pkg::entry_t ent_q_reg;
    tcpq_pkg::slot_t  lnk_q_reg;

    always_ff @(posedge aclk) begin
        if (req.ent_we) begin
            ent_mem[req.ent_addr] <= req.ent_data;
        end
        if (req.lnk_we) begin
            lnk_mem[req.lnk_addr] <= req.lnk_data;
        end
        if (req.rd_en) begin
            ent_q_reg <= ent_mem[req.rd_addr];
            lnk_q_reg <= lnk_mem[req.rd_addr];
        end
    end

    assign rsp.ent = ent_q_reg;
    assign rsp.lnk = lnk_q_reg;

endmodule

[hdl/tcpq_ctrl.sv]
// Queue control: class lists, free chain, sequencer and result register.
module tcpq_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  tcpq_pkg::in_t      s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output tcpq_pkg::out_t     m_data,
    output tcpq_pkg::mem_req_t mem_req,
    input  tcpq_pkg::mem_rsp_t mem_rsp
);

    tcpq_pkg::state_t   state_reg, state_next;
    tcpq_pkg::in_t      item_reg;
    tcpq_pkg::slot_t    rd_slot_reg;
    tcpq_pkg::slot_t    heads_reg  [tcpq_pkg::NCLASS];
    tcpq_pkg::slot_t    heads_next [tcpq_pkg::NCLASS];
    tcpq_pkg::slot_t    tails_reg  [tcpq_pkg::NCLASS];
    tcpq_pkg::slot_t    tails_next [tcpq_pkg::NCLASS];
    tcpq_pkg::cnt_t     counts_reg [tcpq_pkg::NCLASS];
    tcpq_pkg::cnt_t     counts_next[tcpq_pkg::NCLASS];
    tcpq_pkg::slot_t    free_head_reg, free_head_next;
    tcpq_pkg::cnt_t     total_reg, total_next;
    tcpq_pkg::cnt_t     hwm_reg, hwm_next;
    logic               m_valid_reg;
    tcpq_pkg::out_t     m_data_reg;
    tcpq_pkg::out_t     result;

    logic               accept;
    logic               exec_go;
    logic               found;
    tcpq_pkg::cls_idx_t pick;
    tcpq_pkg::cls_idx_t q_ins;
    logic               cls_ok;
    logic               full;
    tcpq_pkg::slot_t    fresh_next;
    tcpq_pkg::slot_t    lnk_val;

    // first nonempty class, smallest class value wins
    always_comb begin
        found = 1'b0;
        pick  = '0;
        for (int i = tcpq_pkg::NCLASS - 1; i >= 0; i--) begin
            if (counts_reg[i] != '0) begin
                found = 1'b1;
                pick  = tcpq_pkg::cls_idx_t'(i);
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            tcpq_pkg::S_IDLE: begin
                if (s_valid) begin
                    state_next = tcpq_pkg::S_EXEC;
                end
            end
            tcpq_pkg::S_EXEC: begin
                if (exec_go) begin
                    state_next = tcpq_pkg::S_IDLE;
                end
            end
            default: state_next = tcpq_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        s_ready = (state_reg == tcpq_pkg::S_IDLE);
        exec_go = (state_reg == tcpq_pkg::S_EXEC) && (!m_valid_reg || m_ready);
    end

    assign accept = s_valid && s_ready;

    // slots at or above the high-water mark were never written: the next slot is their link
    assign fresh_next = (rd_slot_reg == tcpq_pkg::slot_t'(tcpq_pkg::CAPACITY - 1)) ?
                        '0 : rd_slot_reg + tcpq_pkg::slot_t'(1);
    assign lnk_val    = (tcpq_pkg::cnt_t'(rd_slot_reg) >= hwm_reg) ? fresh_next : mem_rsp.lnk;

    assign q_ins  = tcpq_pkg::cls_idx_t'(item_reg.item_class - 2'(tcpq_pkg::CLASS_MIN));
    assign cls_ok = (item_reg.item_class >= 2'(tcpq_pkg::CLASS_MIN)) &&
                    (item_reg.item_class <= 2'(tcpq_pkg::CLASS_MAX));
    assign full   = (total_reg >= tcpq_pkg::cnt_t'(tcpq_pkg::CAPACITY));

    always_comb begin
        heads_next     = heads_reg;
        tails_next     = tails_reg;
        counts_next    = counts_reg;
        free_head_next = free_head_reg;
        total_next     = total_reg;
        hwm_next       = hwm_reg;

        mem_req.rd_en    = accept;
        mem_req.rd_addr  = (s_data.mode == tcpq_pkg::MODE_DISPATCH) ? heads_reg[pick]
                                                                     : free_head_reg;
        mem_req.ent_we   = 1'b0;
        mem_req.ent_addr = free_head_reg;
        mem_req.ent_data.id     = item_reg.item_id;
        mem_req.ent_data.cls    = item_reg.item_class;
        mem_req.ent_data.weight = item_reg.item_weight;
        mem_req.lnk_we   = 1'b0;
        mem_req.lnk_addr = tails_reg[q_ins];
        mem_req.lnk_data = free_head_reg;

        result.status     = tcpq_pkg::ST_QUEUED;
        result.out_id     = '0;
        result.out_class  = '0;
        result.out_weight = '0;

        if (item_reg.mode == tcpq_pkg::MODE_REGISTER) begin
            if (!cls_ok) begin
                result.status = tcpq_pkg::ST_BADCLASS;
            end else if (full) begin
                result.status = tcpq_pkg::ST_FULL;
            end else begin
                result.status  = tcpq_pkg::ST_QUEUED;
                mem_req.ent_we = exec_go;
                free_head_next = lnk_val;
                if (counts_reg[q_ins] != '0) begin
                    mem_req.lnk_we = exec_go;
                end else begin
                    heads_next[q_ins] = free_head_reg;
                end
                tails_next[q_ins]  = free_head_reg;
                counts_next[q_ins] = counts_reg[q_ins] + tcpq_pkg::cnt_t'(1);
                total_next         = total_reg + tcpq_pkg::cnt_t'(1);
                if (tcpq_pkg::cnt_t'(free_head_reg) >= hwm_reg) begin
                    hwm_next = tcpq_pkg::cnt_t'(free_head_reg) + tcpq_pkg::cnt_t'(1);
                end
            end
        end else begin
            if (!found) begin
                result.status = tcpq_pkg::ST_EMPTY;
            end else begin
                result.status     = tcpq_pkg::ST_DISPATCHED;
                result.out_id     = mem_rsp.ent.id;
                result.out_class  = mem_rsp.ent.cls;
                result.out_weight = mem_rsp.ent.weight;
                heads_next[pick]  = lnk_val;
                counts_next[pick] = counts_reg[pick] - tcpq_pkg::cnt_t'(1);
                total_next        = total_reg - tcpq_pkg::cnt_t'(1);
                free_head_next    = rd_slot_reg;
                mem_req.lnk_we    = exec_go;
                mem_req.lnk_addr  = rd_slot_reg;
            end
        end

        result.fill_level = 7'(total_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= tcpq_pkg::S_IDLE;
            heads_reg     <= '{default: '0};
            tails_reg     <= '{default: '0};
            counts_reg    <= '{default: '0};
            free_head_reg <= '0;
            total_reg     <= '0;
            hwm_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (exec_go) begin
                heads_reg     <= heads_next;
                tails_reg     <= tails_next;
                counts_reg    <= counts_next;
                free_head_reg <= free_head_next;
                total_reg     <= total_next;
                hwm_reg       <= hwm_next;
                m_valid_reg   <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg    <= s_data;
            rd_slot_reg <= mem_req.rd_addr;
        end
        if (exec_go) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

[hdl/tcpq_checker.sv]
// Port-level checks for the three-class priority queue, bound to the top level.
module tcpq_props (
    input logic           aclk,
    input logic           aresetn,
    input logic           m_valid,
    input logic           m_ready,
    input tcpq_pkg::out_t m_data
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed or dropped while stalled");

    a_zero_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != tcpq_pkg::ST_DISPATCHED |->
            m_data.out_id == '0 && m_data.out_class == '0 && m_data.out_weight == '0)
        else $error("entry fields nonzero without dispatch");

    a_empty_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == tcpq_pkg::ST_EMPTY |-> m_data.fill_level == '0)
        else $error("empty answer with nonzero fill");

    a_disp_class: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == tcpq_pkg::ST_DISPATCHED |-> m_data.out_class != '0)
        else $error("dispatched entry carries class zero");

    a_queued_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == tcpq_pkg::ST_QUEUED |-> m_data.fill_level != '0)
        else $error("queued answer with zero fill");

endmodule

bind three_class_priority_queue tcpq_props u_tcpq_props (.*);
